// File: hdl/pmps_pkg.sv
// Shared types, codes and helper functions of the PIM/memory phase switch policy
`timescale 1ns / 1ps
package pmps_pkg;

    // event kinds carried on tuser
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MEM  = 2'd1;
    localparam logic [1:0] KIND_PIM  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_MEM_QUEUE_SIZE  = 3'd0;
    localparam logic [2:0] CFG_PIM_QUEUE_SIZE  = 3'd1;
    localparam logic [2:0] CFG_SWITCH_BATCHES  = 3'd2;
    localparam logic [2:0] CFG_MAX_MIN_BATCHES = 3'd3;
    localparam logic [2:0] CFG_RATIO_HIGH      = 3'd4;
    localparam logic [2:0] CFG_RATIO_LOW       = 3'd5;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QSIZE_W     = 13;
    localparam int OUT_TDATA_W = 32;

    // growth is only defined for phase lengths below 2^48
    localparam int GROWTH_PLEN_BITS = 48;

    // objective thresholds in Q0.16
    localparam logic [15:0] OBJ_SMALL = 16'd3276;
    localparam logic [15:0] OBJ_MID   = 16'd6553;
    localparam logic [15:0] OBJ_LARGE = 16'd32768;

    // ratio steps in Q8.8
    localparam logic [15:0] STEP_FINE   = 16'd51;
    localparam logic [15:0] STEP_HALF   = 16'd128;
    localparam logic [15:0] STEP_WHOLE  = 16'd256;
    localparam logic [15:0] RATIO_RESET = 16'd256;

    typedef struct packed {
        logic load;
        logic dec;
        logic mul;
        logic div_start;
        logic div_sel_pim;
        logic store_mem;
        logic store_pim;
        logic adapt;
        logic swt;
        logic fin;
    } pmps_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic need_adapt;
        logic div_done;
        logic out_valid;
    } pmps_sts_t;

    // saturating increment bounded by the high limit
    function automatic logic [15:0] ratio_up(input logic [15:0] r, input logic [15:0] d,
                                             input logic [15:0] hi);
        logic [16:0] s;
        s = {1'b0, r} + {1'b0, d};
        return (s < {1'b0, hi}) ? s[15:0] : hi;
    endfunction

    // decrement that falls back to the low limit
    function automatic logic [15:0] ratio_down(input logic [15:0] r, input logic [15:0] d,
                                               input logic [15:0] lo);
        logic [16:0] t;
        t = {1'b0, lo} + {1'b0, d};
        return ({1'b0, r} >= t) ? (r - d) : lo;
    endfunction

    // (hi - lo) / 2, zero when the bounds are crossed
    function automatic logic [15:0] ratio_mid(input logic [15:0] hi, input logic [15:0] lo);
        logic [15:0] diff;
        diff = hi - lo;
        return (hi < lo) ? 16'd0 : {1'b0, diff[15:1]};
    endfunction

endpackage

// File: hdl/pim_memory_phase_switch_policy_top.sv
// Top level of the PIM/memory phase switch policy
//
//  channel  direction  payload
//  s_       in         tuser: kind; tdata: cycle, rd_busy, wr_busy, pim_busy,
//                      pim_head_row, granted_row, total_pending_sum, pim_pending_sum
//  m_       out        tdata: mode, went_to_memory, went_to_pim, time_ratio, min_batches
//  cfg_     in         register index, write data
//
//  A grant is loaded and decoded; a tick is then switched and finished, and when the
//  phase update runs, the growth figures pass one shared divider at one bit per cycle.
//  Reset is synchronous, active low, and restores the register defaults.
//  One request is in work at a time; a new one is taken while the last result waits
//  only if the result is taken in the same cycle.
`timescale 1ns / 1ps
module pim_memory_phase_switch_policy_top import pmps_pkg::*; #(
    parameter int PHASE_CYCLES = 1024,
    parameter int ROW_BITS     = 16,
    parameter int CYCLE_BITS   = 48,
    localparam int IN_BITS     = CYCLE_BITS + 67 + 2 * ROW_BITS,
    localparam int IN_W        = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_wr_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // cycle, rd_busy, wr_busy, pim_busy, pim_head_row, granted_row,
    // total_pending_sum, pim_pending_sum
    input  logic [IN_W-1:0]        s_tdata,
    // kind
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // mode, went_to_memory, went_to_pim, time_ratio, min_batches
    output logic [OUT_TDATA_W-1:0] m_tdata
);
    pmps_cmd_t cmd;
    pmps_sts_t sts;

    pmps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pmps_dp #(
        .PHASE_CYCLES (PHASE_CYCLES),
        .ROW_BITS     (ROW_BITS),
        .CYCLE_BITS   (CYCLE_BITS),
        .IN_W         (IN_W)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_addr (cfg_wr_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .sts         (sts)
    );
endmodule

// File: hdl/pmps_div.sv
// Restoring divider giving a saturated 16-bit quotient, one bit per cycle
`timescale 1ns / 1ps
module pmps_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 61
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [15:0]      quo
);
    localparam int DW = DEN_W + 16;

    logic          busy_reg;
    logic          done_reg;
    logic [4:0]    cnt_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [DW-1:0] dsh_reg;
    logic [16:0]   q_reg;
    logic          ge;

    assign ge = DW'(rem_reg) >= dsh_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 5'd1) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one quotient bit per step, bit 16 flags saturation
    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= 5'd17;
            rem_reg <= num;
            dsh_reg <= {den, 16'd0};
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
            end
            q_reg   <= {q_reg[15:0], ge};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 5'd1;
        end
    end

    assign done = done_reg;
    assign quo  = q_reg[16] ? 16'hFFFF : q_reg[15:0];
endmodule

// File: hdl/pmps_ctrl.sv
// Sequencer of the phase switch policy
`timescale 1ns / 1ps
module pmps_ctrl import pmps_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      m_tready,
    input  pmps_sts_t sts,
    output pmps_cmd_t cmd
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_DEC   = 4'd1;
    localparam logic [3:0] ST_MUL   = 4'd2;
    localparam logic [3:0] ST_STA   = 4'd3;
    localparam logic [3:0] ST_WTA   = 4'd4;
    localparam logic [3:0] ST_WTP   = 4'd5;
    localparam logic [3:0] ST_ADAPT = 4'd6;
    localparam logic [3:0] ST_SWT   = 4'd7;
    localparam logic [3:0] ST_FIN   = 4'd8;

    logic [3:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE) && (!sts.out_valid || m_tready);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DEC;
                end
            end
            ST_DEC: begin
                cmd.dec = 1'b1;
                if (!sts.is_tick) begin
                    state_next = ST_IDLE;
                end else if (sts.need_adapt) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_SWT;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_STA;
            end
            ST_STA: begin
                cmd.div_start = 1'b1;
                state_next    = ST_WTA;
            end
            ST_WTA: begin
                if (sts.div_done) begin
                    cmd.store_mem   = 1'b1;
                    cmd.div_start   = 1'b1;
                    cmd.div_sel_pim = 1'b1;
                    state_next      = ST_WTP;
                end
            end
            ST_WTP: begin
                if (sts.div_done) begin
                    cmd.store_pim = 1'b1;
                    state_next    = ST_ADAPT;
                end
            end
            ST_ADAPT: begin
                cmd.adapt  = 1'b1;
                state_next = ST_SWT;
            end
            ST_SWT: begin
                cmd.swt    = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin    = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end
endmodule

// File: hdl/pmps_dp.sv
// Datapath of the phase switch policy: state, growth measure, ratio adaptation
`timescale 1ns / 1ps
module pmps_dp import pmps_pkg::*; #(
    parameter int PHASE_CYCLES = 1024,
    parameter int ROW_BITS     = 16,
    parameter int CYCLE_BITS   = 48,
    parameter int IN_W         = 152
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_wr_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic [IN_W-1:0]        s_tdata,
    input  logic [1:0]             s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  pmps_cmd_t              cmd,
    output pmps_sts_t              sts
);
    localparam int CB    = CYCLE_BITS;
    localparam int RB    = ROW_BITS;
    localparam int NUM_W = 48;
    localparam int DEN_W = CB + QSIZE_W;
    localparam int PRD_W = CB + 16;
    localparam logic [CB-1:0] CYC_MAX = '1;
    localparam logic [CB-1:0] PHASE = CB'(PHASE_CYCLES);

    // configuration
    logic [QSIZE_W-1:0] mem_qsize_reg, pim_qsize_reg;
    logic [7:0]  switch_batches_reg, max_min_reg;
    logic [15:0] ratio_high_reg, ratio_low_reg;

    // policy state
    logic          mode_reg;
    logic [RB-1:0] last_row_reg;
    logic [CB-1:0] batch_start_reg, plen_reg, mps_reg, next_update_reg;
    logic [7:0]    fb_reg, ab_reg;
    logic [15:0]   ratio_reg;
    logic [31:0]   prev_mem_reg, prev_pim_reg;

    // latched request
    logic [1:0]    kind_reg;
    logic [CB-1:0] cycle_reg;
    logic          rd_reg, wr_reg, pim_reg;
    logic [RB-1:0] head_reg, grow_reg;
    logic [31:0]   total_reg, pims_reg;

    // working registers
    logic [CB-1:0]    aplen_reg;
    logic [DEN_W-1:0] den_mem_reg, den_pim_reg;
    logic [15:0]      qa_reg, qp_reg;
    logic [PRD_W-1:0] prod_reg;

    // output register
    logic        out_valid_reg;
    logic        o_mode_reg, o_tomem_reg, o_topim_reg;
    logic [15:0] o_ratio_reg;
    logic [7:0]  o_ab_reg;

    logic mem_work, batch_cond, plen_ovf;
    logic [31:0] mem_pend;
    logic [QSIZE_W-1:0] mq, pq;
    logic div_start, div_done;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic [15:0] div_quo;

    assign mem_work   = rd_reg || wr_reg;
    assign batch_cond = (batch_start_reg != '0) && (!pim_reg || head_reg != last_row_reg);
    assign mem_pend   = total_reg - pims_reg;
    assign mq         = (mem_qsize_reg == '0) ? QSIZE_W'(1) : mem_qsize_reg;
    assign pq         = (pim_qsize_reg == '0) ? QSIZE_W'(1) : pim_qsize_reg;
    assign plen_ovf   = (aplen_reg >> GROWTH_PLEN_BITS) != '0;

    assign sts.is_tick    = kind_reg == KIND_TICK;
    assign sts.need_adapt = (!mode_reg || batch_cond) && (cycle_reg >= next_update_reg);
    assign sts.div_done   = div_done;
    assign sts.out_valid  = out_valid_reg;

    // shared divider for both growth figures
    assign div_start = cmd.div_start;
    assign div_num   = cmd.div_sel_pim ? {pims_reg - prev_pim_reg, 16'd0}
                                       : {mem_pend - prev_mem_reg, 16'd0};
    assign div_den   = cmd.div_sel_pim ? den_pim_reg : den_mem_reg;

    pmps_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ratio and batch adaptation
    logic        a_gt;
    logic [15:0] obj, up_fine, dn_fine, ratio_new;
    logic [7:0]  ab_new;
    logic [8:0]  ab_inc, ab_dbl;

    always_comb begin
        a_gt      = qa_reg > qp_reg;
        obj       = a_gt ? (qa_reg - qp_reg) : (qp_reg - qa_reg);
        up_fine   = ratio_up(ratio_reg, STEP_FINE, ratio_high_reg);
        dn_fine   = ratio_down(ratio_reg, STEP_FINE, ratio_low_reg);
        ab_inc    = {1'b0, ab_reg} + 9'd1;
        ab_dbl    = {ab_reg, 1'b0};
        ratio_new = ratio_reg;
        ab_new    = ab_reg;
        if (obj > OBJ_SMALL) begin
            if (a_gt) begin
                if (obj <= OBJ_MID) begin
                    ratio_new = up_fine;
                    if (up_fine == ratio_high_reg && ab_reg > 8'd1) begin
                        ab_new    = ab_reg - 8'd1;
                        ratio_new = ratio_mid(ratio_high_reg, ratio_low_reg);
                    end
                end else if (obj <= OBJ_LARGE) begin
                    ab_new    = (ab_reg > 8'd1) ? ab_reg - 8'd1 : 8'd1;
                    ratio_new = ratio_up(ratio_reg, STEP_HALF, ratio_high_reg);
                end else begin
                    ab_new    = 8'd1;
                    ratio_new = ratio_up(ratio_reg, STEP_WHOLE, ratio_high_reg);
                end
            end else begin
                if (obj <= OBJ_MID) begin
                    ratio_new = dn_fine;
                    if (dn_fine == ratio_low_reg && ab_reg < max_min_reg) begin
                        ab_new    = ab_reg + 8'd1;
                        ratio_new = ratio_mid(ratio_high_reg, ratio_low_reg);
                    end
                end else if (obj <= OBJ_LARGE) begin
                    ab_new    = (ab_inc < {1'b0, max_min_reg}) ? ab_inc[7:0] : max_min_reg;
                    ratio_new = ratio_down(ratio_reg, STEP_HALF, ratio_low_reg);
                end else begin
                    ab_new    = (ab_dbl < {1'b0, max_min_reg}) ? ab_dbl[7:0] : max_min_reg;
                    ratio_new = ratio_low_reg;
                end
            end
        end
    end

    // finishing step: batch close and mode decision
    logic [CB-1:0] dur, swt_time;
    logic [CB:0]   plen_sum, swt_sum;
    logic [7:0]    fb_inc;
    logic [PRD_W-1:0] prod_sh;
    logic [CB-1:0] prod_sat;

    always_comb begin
        dur      = cycle_reg - batch_start_reg;
        plen_sum = {1'b0, plen_reg} + {1'b0, dur};
        fb_inc   = (fb_reg < 8'd255) ? fb_reg + 8'd1 : fb_reg;
        prod_sh  = prod_reg >> 8;
        prod_sat = ((prod_sh >> CB) != '0) ? CYC_MAX : prod_sh[CB-1:0];
        swt_sum  = {1'b0, mps_reg} + {1'b0, prod_sat};
        swt_time = swt_sum[CB] ? CYC_MAX : swt_sum[CB-1:0];
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_qsize_reg      <= QSIZE_W'(64);
            pim_qsize_reg      <= QSIZE_W'(64);
            switch_batches_reg <= 8'd1;
            max_min_reg        <= 8'd8;
            ratio_high_reg     <= 16'd1024;
            ratio_low_reg      <= 16'd128;
        end else if (cfg_wr_en) begin
            case (cfg_wr_addr)
                CFG_MEM_QUEUE_SIZE:  mem_qsize_reg      <= cfg_wr_data[QSIZE_W-1:0];
                CFG_PIM_QUEUE_SIZE:  pim_qsize_reg      <= cfg_wr_data[QSIZE_W-1:0];
                CFG_SWITCH_BATCHES:  switch_batches_reg <= cfg_wr_data[7:0];
                CFG_MAX_MIN_BATCHES: max_min_reg        <= cfg_wr_data[7:0];
                CFG_RATIO_HIGH:      ratio_high_reg     <= cfg_wr_data;
                CFG_RATIO_LOW:       ratio_low_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // request latch and working registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= s_tuser;
            cycle_reg <= s_tdata[CB-1:0];
            rd_reg    <= s_tdata[CB];
            wr_reg    <= s_tdata[CB+1];
            pim_reg   <= s_tdata[CB+2];
            head_reg  <= s_tdata[CB+3 +: RB];
            grow_reg  <= s_tdata[CB+3+RB +: RB];
            total_reg <= s_tdata[CB+3+2*RB +: 32];
            pims_reg  <= s_tdata[CB+35+2*RB +: 32];
        end
        if (cmd.dec) begin
            aplen_reg <= cycle_reg - next_update_reg + PHASE;
        end
        if (cmd.mul) begin
            den_mem_reg <= DEN_W'(aplen_reg * mq);
            den_pim_reg <= DEN_W'(aplen_reg * pq);
        end
        if (cmd.store_mem) begin
            qa_reg <= plen_ovf ? 16'd0 : div_quo;
        end
        if (cmd.store_pim) begin
            qp_reg <= plen_ovf ? 16'd0 : div_quo;
        end
        if (cmd.swt) begin
            prod_reg <= PRD_W'(plen_reg * ratio_reg);
        end
    end

    // policy state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= 1'b0;
            last_row_reg    <= '0;
            batch_start_reg <= '0;
            plen_reg        <= '0;
            mps_reg         <= '0;
            next_update_reg <= PHASE;
            fb_reg          <= 8'd0;
            ab_reg          <= 8'd1;
            ratio_reg       <= RATIO_RESET;
            prev_mem_reg    <= 32'd0;
            prev_pim_reg    <= 32'd0;
        end else begin
            if (cmd.dec && kind_reg == KIND_MEM) begin
                if (mps_reg == '0) mps_reg <= cycle_reg;
            end
            if (cmd.dec && kind_reg == KIND_PIM) begin
                if (batch_start_reg == '0) batch_start_reg <= cycle_reg;
                last_row_reg <= grow_reg;
            end
            if (cmd.adapt) begin
                ratio_reg       <= ratio_new;
                ab_reg          <= ab_new;
                prev_mem_reg    <= mem_pend;
                prev_pim_reg    <= pims_reg;
                next_update_reg <= cycle_reg + PHASE;
            end
            if (cmd.fin) begin
                if (mode_reg) begin
                    if (batch_cond) begin
                        batch_start_reg <= '0;
                        if (fb_inc <= ab_reg) begin
                            plen_reg <= plen_sum[CB] ? CYC_MAX : plen_sum[CB-1:0];
                        end
                    end
                    if (((batch_cond ? fb_inc : fb_reg) >= switch_batches_reg || !pim_reg)
                        && mem_work) begin
                        fb_reg   <= 8'd0;
                        mode_reg <= 1'b0;
                    end else if (batch_cond) begin
                        fb_reg <= fb_inc;
                    end
                end else if (pim_reg && ((mps_reg != '0 && cycle_reg > swt_time) || !mem_work))
                begin
                    plen_reg <= '0;
                    mps_reg  <= '0;
                    mode_reg <= 1'b1;
                end
            end
        end
    end

    // result register
    logic fin_tomem, fin_topim;
    assign fin_tomem = mode_reg && mem_work &&
                       ((batch_cond ? fb_inc : fb_reg) >= switch_batches_reg || !pim_reg);
    assign fin_topim = !mode_reg && pim_reg &&
                       ((mps_reg != '0 && cycle_reg > swt_time) || !mem_work);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.dec && kind_reg != KIND_TICK) || cmd.fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dec && kind_reg != KIND_TICK) begin
            o_mode_reg  <= mode_reg;
            o_tomem_reg <= 1'b0;
            o_topim_reg <= 1'b0;
            o_ratio_reg <= ratio_reg;
            o_ab_reg    <= ab_reg;
        end else if (cmd.fin) begin
            o_mode_reg  <= fin_tomem ? 1'b0 : (fin_topim ? 1'b1 : mode_reg);
            o_tomem_reg <= fin_tomem;
            o_topim_reg <= fin_topim;
            o_ratio_reg <= ratio_reg;
            o_ab_reg    <= ab_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, o_ab_reg, o_ratio_reg, o_topim_reg, o_tomem_reg, o_mode_reg};
endmodule

// File: tb/tb_pim_memory_phase_switch_policy_top.sv
// Self-checking testbench for the PIM/memory phase switch policy top level
`timescale 1ns / 1ps
module tb_pim_memory_phase_switch_policy_top;
    import pmps_pkg::*;

    localparam int IN_W = 152;
    localparam logic [63:0] CYC_MASK = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHASE = 64'd1024;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] cycle;
        logic        rd;
        logic        wr;
        logic        pm;
        logic [15:0] head;
        logic [15:0] grow;
        logic [31:0] total;
        logic [31:0] pims;
    } event_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_wr_addr = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_W-1:0]        s_tdata = '0;
    logic [1:0]             s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    pim_memory_phase_switch_policy_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_addr(cfg_wr_addr), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #2 aclk = ~aclk;

    // pending requests and expected policy results
    event_t          pending_events[$];
    logic [31:0]     expected_status[$];
    int              n_accepted = 0;
    int              n_seen = 0;
    int              n_results = 0;
    int              n_errors = 0;
    int              n_to_pim = 0;
    int              n_to_mem = 0;

    // predictor configuration copy
    logic [63:0] c_memq, c_pimq, c_switch, c_maxmin, c_hi, c_lo;
    // predictor state copy
    logic        p_is_pim;
    logic [63:0] p_last_row, p_batch_start, p_plen, p_mem_start, p_next_update;
    logic [31:0] p_finished, p_batches, p_ratio, p_prev_mem, p_prev_pim;

    task automatic model_reset();
        c_memq = 64; c_pimq = 64; c_switch = 1; c_maxmin = 8; c_hi = 1024; c_lo = 128;
        p_is_pim = 1'b0; p_last_row = 0; p_batch_start = 0; p_plen = 0; p_mem_start = 0;
        p_next_update = PHASE; p_finished = 0; p_batches = 1; p_ratio = RATIO_RESET;
        p_prev_mem = 0; p_prev_pim = 0;
    endtask

    function automatic logic [31:0] growth_q16(input logic [31:0] d, input logic [63:0] plen,
                                               input logic [63:0] q);
        logic [63:0] den, quo;
        if (q == 0) q = 1;
        if ((plen >> GROWTH_PLEN_BITS) != 0) return 0;
        den = plen * q;
        if (den == 0) return 65535;
        quo = ({32'b0, d} << 16) / den;
        return (quo > 65535) ? 32'd65535 : quo[31:0];
    endfunction

    function automatic logic [31:0] mid_ratio();
        logic [63:0] diff;
        if (c_hi < c_lo) return 0;
        diff = (c_hi - c_lo) >> 1;
        return diff[31:0];
    endfunction

    function automatic logic [31:0] raise_ratio(input logic [31:0] d);
        logic [63:0] r;
        r = {32'b0, p_ratio} + d;
        return (r < c_hi) ? r[31:0] : c_hi[31:0];
    endfunction

    function automatic logic [31:0] lower_ratio(input logic [31:0] d);
        if ({32'b0, p_ratio} >= c_lo + d) return p_ratio - d;
        return c_lo[31:0];
    endfunction

    // once-per-phase adaptation of ratio and minimum batches
    task automatic adapt_phase(input logic [63:0] cyc, input logic [31:0] total,
                               input logic [31:0] pim);
        logic [63:0] plen;
        logic [31:0] mem, qa, qp, obj, n;
        if (cyc < p_next_update) return;
        plen = (cyc - p_next_update + PHASE) & CYC_MASK;
        mem = total - pim;
        qa = growth_q16(mem - p_prev_mem, plen, c_memq);
        qp = growth_q16(pim - p_prev_pim, plen, c_pimq);
        obj = (qa > qp) ? qa - qp : qp - qa;
        if (obj > OBJ_SMALL) begin
            if (qa > qp) begin
                if (obj <= OBJ_MID) begin
                    p_ratio = raise_ratio(STEP_FINE);
                    if (p_ratio == c_hi && p_batches > 1) begin
                        p_batches = p_batches - 1;
                        p_ratio = mid_ratio();
                    end
                end else if (obj <= OBJ_LARGE) begin
                    p_batches = (p_batches > 1) ? p_batches - 1 : 1;
                    p_ratio = raise_ratio(STEP_HALF);
                end else begin
                    p_batches = 1;
                    p_ratio = raise_ratio(STEP_WHOLE);
                end
            end else begin
                if (obj <= OBJ_MID) begin
                    p_ratio = lower_ratio(STEP_FINE);
                    if (p_ratio == c_lo && p_batches < c_maxmin) begin
                        p_batches = p_batches + 1;
                        p_ratio = mid_ratio();
                    end
                end else if (obj <= OBJ_LARGE) begin
                    n = p_batches + 1;
                    p_batches = (n < c_maxmin) ? n : c_maxmin[31:0];
                end else begin
                    n = p_batches * 2;
                    p_batches = (n < c_maxmin) ? n : c_maxmin[31:0];
                end
                if (obj > OBJ_MID) begin
                    if (obj <= OBJ_LARGE) p_ratio = lower_ratio(STEP_HALF);
                    else p_ratio = c_lo[31:0];
                end
            end
        end
        p_prev_mem = mem;
        p_prev_pim = pim;
        p_next_update = (cyc + PHASE) & CYC_MASK;
    endtask

    function automatic logic [63:0] switch_point();
        logic [63:0] a, b, r, prod, s;
        a = p_plen >> 8;
        b = p_plen & 64'hff;
        r = {32'b0, p_ratio};
        if (r != 0 && a > CYC_MASK / r) return CYC_MASK;
        prod = a * r + ((b * r) >> 8);
        if (prod > CYC_MASK) return CYC_MASK;
        s = p_mem_start + prod;
        return (s > CYC_MASK) ? CYC_MASK : s;
    endfunction

    // predicted status word for one event
    task automatic predict_status(input event_t ev, output logic [31:0] status);
        logic [63:0] cyc, dur, s;
        logic        mem_work, to_mem, to_pim;
        cyc = {16'b0, ev.cycle};
        mem_work = ev.rd | ev.wr;
        to_mem = 1'b0;
        to_pim = 1'b0;
        if (ev.kind == KIND_MEM) begin
            if (p_mem_start == 0) p_mem_start = cyc;
        end else if (ev.kind == KIND_PIM) begin
            if (p_batch_start == 0) p_batch_start = cyc;
            p_last_row = {48'b0, ev.grow};
        end else if (ev.kind == KIND_TICK) begin
            if (p_is_pim) begin
                if (p_batch_start > 0 && (!ev.pm || {48'b0, ev.head} != p_last_row)) begin
                    adapt_phase(cyc, ev.total, ev.pims);
                    dur = (cyc - p_batch_start) & CYC_MASK;
                    p_batch_start = 0;
                    if (p_finished < 255) p_finished = p_finished + 1;
                    if (p_finished <= p_batches) begin
                        s = p_plen + dur;
                        p_plen = (s > CYC_MASK || s < dur) ? CYC_MASK : s;
                    end
                end
                if (({32'b0, p_finished} >= c_switch || !ev.pm) && mem_work) begin
                    p_finished = 0;
                    p_is_pim = 1'b0;
                    to_mem = 1'b1;
                end
            end else begin
                adapt_phase(cyc, ev.total, ev.pims);
                if (ev.pm && ((p_mem_start > 0 && cyc > switch_point()) || !mem_work)) begin
                    p_plen = 0;
                    p_mem_start = 0;
                    p_is_pim = 1'b1;
                    to_pim = 1'b1;
                end
            end
        end
        status = {5'b0, p_batches[7:0], p_ratio[15:0], to_pim, to_mem, p_is_pim};
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < 30)
            $display("mismatch at result %0d: %s got %0d expected %0d",
                     n_results, what, got, want);
        n_errors++;
    endtask

    // request side: accept, predict, and check results
    always @(posedge aclk) begin
        logic [31:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            predict_status(pending_events[0], want);
            expected_status.push_back(want);
            void'(pending_events.pop_front());
            n_accepted <= n_accepted + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_status.pop_front();
                if (m_tdata[0] !== want[0]) report_mismatch("mode", m_tdata[0], want[0]);
                if (m_tdata[1] !== want[1])
                    report_mismatch("went_to_memory", m_tdata[1], want[1]);
                if (m_tdata[2] !== want[2]) report_mismatch("went_to_pim", m_tdata[2], want[2]);
                if (m_tdata[18:3] !== want[18:3])
                    report_mismatch("time_ratio", m_tdata[18:3], want[18:3]);
                if (m_tdata[26:19] !== want[26:19])
                    report_mismatch("min_batches", m_tdata[26:19], want[26:19]);
                n_to_pim += want[2];
                n_to_mem += want[1];
            end
            n_results++;
        end
    end

    // driver: bursts of requests with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && n_accepted == n_seen) begin
            // hold the current request
        end else begin
            n_seen = n_accepted;
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (pending_events.size() != 0) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
                end
                burst_left--;
                s_tvalid <= 1'b1;
                s_tuser  <= pending_events[0].kind;
                s_tdata  <= {5'b0, pending_events[0].pims, pending_events[0].total,
                             pending_events[0].grow, pending_events[0].head,
                             pending_events[0].pm, pending_events[0].wr, pending_events[0].rd,
                             pending_events[0].cycle};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: phases of always ready, random, and periodic
    int ready_cnt = 0;
    always @(negedge aclk) begin
        ready_cnt++;
        case ((ready_cnt / 300) % 3)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 6);
            default: m_tready <= (ready_cnt % 4 == 0);
        endcase
    end

    // watchdog on stalled handshakes
    int idle_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (pending_events.size() == 0 && expected_status.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_status.size());
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // stimulus generation state
    logic [47:0] gen_cycle;
    logic [31:0] gen_total, gen_pims;

    task automatic push_event(input logic [1:0] kind, input logic [47:0] cyc, input logic rd,
                              input logic wr, input logic pm, input logic [15:0] head,
                              input logic [15:0] grow, input logic [31:0] total,
                              input logic [31:0] pims);
        event_t ev;
        ev = '{kind, cyc, rd, wr, pm, head, grow, total, pims};
        pending_events.push_back(ev);
    endtask

    // advance time and queue sums, then queue one event
    task automatic push_next(input logic [1:0] kind, input logic rd, input logic wr,
                             input logic pm, input logic [15:0] head, input logic [15:0] grow);
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 70) gen_cycle = gen_cycle + $urandom_range(1, 20);
        else if (sel < 97) gen_cycle = gen_cycle + $urandom_range(100, 1500);
        else if (sel < 99) gen_cycle = {$urandom, $urandom} & CYC_MASK;
        else gen_cycle = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 3000);
        gen_total = gen_total + $urandom_range(0, 300);
        gen_pims = gen_pims + $urandom_range(0, 150);
        if ($urandom_range(0, 40) == 0) begin
            gen_total = $urandom;
            gen_pims = $urandom;
        end
        push_event(kind, gen_cycle, rd, wr, pm, head, grow, gen_total, gen_pims);
    endtask

    function automatic logic [15:0] pick_row();
        return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
    endfunction

    // a well-formed PIM episode: enter, run batches, then leave with memory work
    task automatic push_episode();
        int nb, ng;
        logic [15:0] row;
        push_next(KIND_MEM, 1'b1, 1'($urandom), 1'b1, pick_row(), pick_row());
        push_next(KIND_TICK, 1'($urandom_range(0, 3) == 0), 1'b0, 1'b1, pick_row(), 0);
        nb = $urandom_range(1, 4);
        for (int i = 0; i < nb; i++) begin
            row = pick_row();
            ng = $urandom_range(1, 4);
            for (int j = 0; j < ng; j++) begin
                push_next(KIND_PIM, 1'($urandom), 1'($urandom), 1'b1, row, row);
                push_next(KIND_TICK, 1'($urandom), 1'($urandom), 1'b1, row, 16'($urandom));
            end
            push_next(KIND_TICK, 1'($urandom), 1'($urandom), 1'($urandom_range(0, 3) != 0),
                      row + 16'd1, 16'($urandom));
        end
        push_next(KIND_TICK, 1'b1, 1'($urandom), 1'($urandom), pick_row(), 16'($urandom));
    endtask

    task automatic push_noise();
        logic [1:0] kind;
        kind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        push_next(kind, 1'($urandom), 1'($urandom), 1'($urandom), pick_row(), pick_row());
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_addr <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_MEM_QUEUE_SIZE:  c_memq   = {51'b0, value[12:0]};
            CFG_PIM_QUEUE_SIZE:  c_pimq   = {51'b0, value[12:0]};
            CFG_SWITCH_BATCHES:  c_switch = {56'b0, value[7:0]};
            CFG_MAX_MIN_BATCHES: c_maxmin = {56'b0, value[7:0]};
            CFG_RATIO_HIGH:      c_hi     = {48'b0, value};
            CFG_RATIO_LOW:       c_lo     = {48'b0, value};
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] mq, input logic [15:0] pq, input logic [15:0] sw,
                             input logic [15:0] mx, input logic [15:0] hi, input logic [15:0] lo);
        write_reg(CFG_MEM_QUEUE_SIZE, mq);
        write_reg(CFG_PIM_QUEUE_SIZE, pq);
        write_reg(CFG_SWITCH_BATCHES, sw);
        write_reg(CFG_MAX_MIN_BATCHES, mx);
        write_reg(CFG_RATIO_HIGH, hi);
        write_reg(CFG_RATIO_LOW, lo);
    endtask

    task automatic drain();
        wait (pending_events.size() == 0 && expected_status.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        model_reset();
        gen_cycle = 0;
        gen_total = 0;
        gen_pims = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: zero cycles, unused kind, field extremes, mode entry and exit
        push_event(KIND_MEM, 0, 1, 0, 0, 0, 0, 0, 0);
        push_event(KIND_PIM, 0, 0, 0, 1, 0, 16'hFFFF, 0, 0);
        push_event(2'd3, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 16'hFFFF, 16'hFFFF, '1, '1);
        push_event(KIND_TICK, 5, 0, 0, 1, 16'hFFFF, 0, 0, 0);
        push_event(KIND_PIM, 10, 0, 0, 1, 7, 7, 0, 0);
        push_event(KIND_TICK, 20, 0, 1, 1, 7, 0, 0, 0);
        push_event(KIND_TICK, 1100, 1, 0, 1, 8, 0, 32'd5000, 32'd10);
        push_event(KIND_MEM, 1200, 1, 1, 1, 0, 0, 32'd5000, 32'd10);
        push_event(KIND_TICK, 2300, 1, 1, 1, 0, 0, 32'd5010, 32'd4000);
        push_event(KIND_PIM, 2400, 1, 0, 1, 3, 3, 32'd5010, 32'd4000);
        push_event(KIND_TICK, 3500, 1, 0, 0, 3, 0, 32'd4000, 32'd5010);
        push_event(KIND_TICK, 48'hFFFF_FFFF_FF00, 0, 0, 1, 0, 0, '1, 0);
        push_event(KIND_PIM, 48'hFFFF_FFFF_FFFF, 1, 1, 1, 16'hFFFF, 16'hFFFF, 0, '1);
        push_event(KIND_TICK, 48'h0000_0000_0100, 1, 1, 0, 16'hAAAA, 16'h5555, 32'h5555_5555,
                   32'hAAAA_AAAA);
        gen_cycle = 48'd4000;
        drain();

        // several register settings, extremes among them
        for (int phase = 0; phase < 7; phase++) begin
            case (phase)
                0: ;
                1: write_all(1, 1, 1, 1, 0, 0);
                2: write_all(4096, 4096, 255, 255, 16'hFFFF, 16'hFFFF);
                3: write_all(64, 8, 2, 16, 200, 900);
                4: write_all(0, 16'h1FFF, 0, 0, 16'hFFFF, 0);
                5: write_all($urandom_range(1, 4096), $urandom_range(1, 4096),
                             $urandom_range(1, 4), $urandom_range(2, 20),
                             $urandom_range(300, 2000), $urandom_range(0, 300));
                default: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            endcase
            while (pending_events.size() < 80) begin
                if ($urandom_range(0, 9) < 6) push_episode();
                else push_noise();
            end
            drain();
        end

        $display("%0d requests and %0d results over 7 register settings", n_accepted, n_results);
        $display("%0d switches into PIM mode, %0d back to memory mode", n_to_pim, n_to_mem);
        if (n_errors == 0 && expected_status.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
